// ===== rtl/ttyld_pkg.sv =====
// shared types, codes and character constants of the tty line discipline
`default_nettype none

package ttyld_pkg;

   localparam int BUF_DEPTH_DEFAULT = 1024;
   localparam int MAX_RESULTS = 6;

   typedef enum logic [1:0] {
      REQ_RECEIVE  = 2'd0,
      REQ_READ     = 2'd1,
      REQ_TRANSMIT = 2'd2,
      REQ_FLUSH    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_STATUS     = 2'd0,
      KIND_TERM       = 2'd1,
      KIND_READ_DATA  = 2'd2,
      KIND_READ_EMPTY = 2'd3
   } out_kind_type;

   typedef enum logic [1:0] {
      SIG_NONE = 2'd0,
      SIG_INTR = 2'd1,
      SIG_SUSP = 2'd2,
      SIG_QUIT = 2'd3
   } sig_type;

   typedef enum logic [2:0] {
      CSR_LOCAL_FLAGS    = 3'd0,
      CSR_NEWLINE_EXPAND = 3'd1,
      CSR_EOF_CHAR       = 3'd2,
      CSR_INTR_CHAR      = 3'd3,
      CSR_SUSP_CHAR      = 3'd4,
      CSR_QUIT_CHAR      = 3'd5,
      CSR_TTY_ATTACHED   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   // local flag bit positions
   localparam int LF_ECHO   = 0;
   localparam int LF_ECHOE  = 1;
   localparam int LF_ECHONL = 2;
   localparam int LF_ICANON = 3;
   localparam int LF_ISIG   = 4;
   localparam int LF_NOFLSH = 5;

   localparam logic [5:0] LOCAL_FLAGS_RESET = 6'd27;
   localparam logic       NEWLINE_EXPAND_RESET = 1'b1;
   localparam logic [7:0] EOF_CHAR_RESET  = 8'h04;
   localparam logic [7:0] INTR_CHAR_RESET = 8'h03;
   localparam logic [7:0] SUSP_CHAR_RESET = 8'h1a;
   localparam logic [7:0] QUIT_CHAR_RESET = 8'h1c;
   localparam logic       TTY_ATTACHED_RESET = 1'b0;

   localparam logic [7:0] CH_DEL   = 8'h7f;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;

   typedef struct packed {
      logic [5:0] local_flags;
      logic       newline_expand;
      logic [7:0] eof_char;
      logic [7:0] intr_char;
      logic [7:0] susp_char;
      logic [7:0] quit_char;
      logic       tty_attached;
   } cfg_type;

   typedef struct packed {
      logic [2:0]      count;
      logic [5:0][7:0] bytes;
   } term_type;

   // everything the result channel shows for one item
   typedef struct packed {
      out_kind_type    kind;
      logic [2:0]      count;
      logic [5:0][7:0] bytes;
      sig_type         sig;
      logic            drop;
      logic            readable;
   } res_type;

   function automatic logic is_ctrl(input logic [7:0] b);
      logic printable;
      logic space;
      printable = (b >= 8'h20) && (b <= 8'h7e);
      space     = (b >= 8'h09) && (b <= 8'h0d);
      return !printable && !space;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ttyld_step.sv =====
// per-item decision logic: pointer updates, store write and result bytes
`default_nettype none

module ttyld_step #(
   parameter int BUF_DEPTH = ttyld_pkg::BUF_DEPTH_DEFAULT,
   parameter int PTR_W = $clog2(BUF_DEPTH)
) (
   input  ttyld_pkg::req_kind_type req_type,
   input  logic [7:0]              in_byte,
   input  ttyld_pkg::cfg_type      cfg,
   input  logic [7:0]              rd_data,
   input  logic [PTR_W-1:0]        start_ptr,
   input  logic [PTR_W-1:0]        cooked_ptr,
   input  logic [PTR_W-1:0]        raw_ptr,
   output logic [PTR_W-1:0]        start_ptr_next,
   output logic [PTR_W-1:0]        cooked_ptr_next,
   output logic [PTR_W-1:0]        raw_ptr_next,
   output logic                    wr_en,
   output logic [PTR_W-1:0]        wr_addr,
   output logic [7:0]              wr_data,
   output ttyld_pkg::res_type      res
);
   import ttyld_pkg::*;

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUF_DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - 1'b1;
   endfunction

   function automatic term_type term_put(input logic [7:0] ch, input logic [7:0] erased,
                                         input logic is_echo, input logic canon,
                                         input logic echoe, input logic nlx);
      term_type t;
      t = '0;
      if (is_echo && ch == CH_DEL && canon && echoe) begin
         t.bytes = {CH_BS, CH_SP, CH_BS, CH_BS, CH_SP, CH_BS};
         if (erased == CH_DEL) begin
            t.count = 3'd0;
         end else if (is_ctrl(erased)) begin
            t.count = 3'd6;
         end else begin
            t.count = 3'd3;
         end
      end else if (ch == CH_LF && nlx) begin
         t.bytes[0] = CH_CR;
         t.bytes[1] = CH_LF;
         t.count    = 3'd2;
      end else if (is_echo && is_ctrl(ch)) begin
         t.bytes[0] = CH_CARET;
         t.bytes[1] = (ch + CH_AT) & 8'h7f;
         t.count    = 3'd2;
      end else begin
         t.bytes[0] = ch;
         t.count    = 3'd1;
      end
      return t;
   endfunction

   logic             canon;
   logic             isig;
   logic             echo_en;
   logic             term_en;
   logic             term_echo;
   logic             handled;
   logic             sig_match;
   logic [7:0]       cv;
   logic [7:0]       echo_byte;
   logic [7:0]       erased;
   logic [PTR_W-1:0] raw_new;
   term_type         term;

   assign canon     = cfg.local_flags[LF_ICANON];
   assign isig      = cfg.local_flags[LF_ISIG];
   assign sig_match = (in_byte == cfg.intr_char) || (in_byte == cfg.susp_char)
                      || (in_byte == cfg.quit_char);

   always_comb begin
      start_ptr_next  = start_ptr;
      cooked_ptr_next = cooked_ptr;
      raw_ptr_next    = raw_ptr;
      wr_en           = 1'b0;
      wr_addr         = raw_ptr;
      wr_data         = in_byte;
      echo_en         = cfg.local_flags[LF_ECHO];
      term_en         = 1'b0;
      term_echo       = 1'b1;
      handled         = 1'b0;
      cv              = in_byte;
      echo_byte       = in_byte;
      erased          = 8'h00;
      raw_new         = raw_ptr;
      term            = '0;
      res             = '0;
      res.kind        = KIND_STATUS;
      res.sig         = SIG_NONE;

      case (req_type)
         REQ_RECEIVE: begin
            if (!(canon && in_byte == CH_DEL) && ptr_inc(raw_ptr) == start_ptr) begin
               res.drop = 1'b1;
            end else if (canon && in_byte == CH_DEL && cooked_ptr == raw_ptr) begin
               // erase at line start does nothing
               res.drop = 1'b0;
            end else begin
               if (canon && in_byte == CH_DEL) begin
                  raw_new = ptr_dec(raw_ptr);
                  erased  = rd_data;
                  handled = 1'b1;
               end else if (canon && in_byte == cfg.eof_char) begin
                  echo_en = 1'b0;
                  handled = 1'b1;
               end
               if (!handled && isig && sig_match) begin
                  if (!cfg.local_flags[LF_NOFLSH]) begin
                     start_ptr_next  = raw_ptr;
                     cooked_ptr_next = raw_ptr;
                  end
                  handled = 1'b1;
               end
               if (!handled) begin
                  if (in_byte == CH_CR) begin
                     cv = CH_LF;
                     if (cfg.newline_expand) begin
                        echo_byte = CH_LF;
                     end
                  end
                  if (cv == CH_LF && canon && cfg.local_flags[LF_ECHONL]) begin
                     echo_en = 1'b1;
                  end
                  wr_en   = 1'b1;
                  wr_data = cv;
                  raw_new = ptr_inc(raw_ptr);
               end
               raw_ptr_next = raw_new;
               if (cv == CH_LF || cv == cfg.eof_char || !canon) begin
                  cooked_ptr_next = raw_new;
               end
               if (cfg.tty_attached && isig) begin
                  if (cv == cfg.intr_char) begin
                     res.sig = SIG_INTR;
                  end else if (cv == cfg.susp_char) begin
                     res.sig = SIG_SUSP;
                  end else if (cv == cfg.quit_char) begin
                     res.sig = SIG_QUIT;
                  end
               end
               term_en = echo_en;
            end
         end
         REQ_READ: begin
            res.count = 3'd1;
            if (start_ptr != cooked_ptr) begin
               res.kind       = KIND_READ_DATA;
               res.bytes[0]   = rd_data;
               start_ptr_next = ptr_inc(start_ptr);
            end else begin
               res.kind = KIND_READ_EMPTY;
            end
         end
         REQ_TRANSMIT: begin
            term_en   = 1'b1;
            term_echo = 1'b0;
            erased    = CH_SP;
         end
         REQ_FLUSH: begin
            start_ptr_next  = raw_ptr;
            cooked_ptr_next = raw_ptr;
         end
         default: begin
            res.drop = 1'b0;
         end
      endcase

      if (term_en) begin
         term = term_put(echo_byte, erased, term_echo, canon,
                         cfg.local_flags[LF_ECHOE], cfg.newline_expand);
         if (term.count != 3'd0) begin
            res.kind  = KIND_TERM;
            res.count = term.count;
            res.bytes = term.bytes;
         end
      end

      // an item with nothing to send still reports its status once
      if (res.count == 3'd0) begin
         res.kind  = KIND_STATUS;
         res.count = 3'd1;
         res.bytes = '0;
      end
      res.readable = (start_ptr_next != cooked_ptr_next);
   end

endmodule

`default_nettype wire

// ===== rtl/tty_canonical_line_discipline.sv =====
// top level of the canonical tty line discipline: store, pointers, sequencer, result buffer
//
// Requests arrive on req_ (tuser = request type, tdata = byte); each one yields one to six
// results on rsp_, the final one marked by rsp_tlast. Request types are receive a byte,
// read one cooked byte, transmit a byte and flush input. The csr_ port writes the mode
// registers; write it only while no request is in flight.
// An accepted request reads the line store at the accept edge, passes through the decide
// state (pointer update and store write), then presents its results one per cycle on rsp_
// while rsp_tready is high. A new request is taken in the same cycle as the last result
// transfer.
// When the receiver stalls, the current result holds and no new request is taken.
// Reset clears the start, cooked and raw pointers and loads the register defaults; the
// store contents are left as they are and nothing is read before it is written.
`default_nettype none

module tty_canonical_line_discipline #(
   parameter int BUF_DEPTH = ttyld_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [9:8] signal_code, [10] dropped,
                                    // [11] readable, [15:12] zero
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import ttyld_pkg::*;

   localparam int PTR_W = $clog2(BUF_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUF_DEPTH - 1);

   logic [7:0]       store_mem [BUF_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] rd_addr;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] start_ptr_ff, cooked_ptr_ff, raw_ptr_ff;
   logic [PTR_W-1:0] start_ptr_in, cooked_ptr_in, raw_ptr_in;
   req_kind_type     req_type_ff;
   logic [7:0]       in_byte_ff;
   cfg_type          cfg_ff;
   res_type          res_ff, res_in;
   logic [2:0]       idx_ff;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             req_fire;
   logic             rsp_fire;
   logic             final_result;

   assign req_fire     = req_tvalid && req_tready;
   assign rsp_fire     = rsp_tvalid && rsp_tready;
   assign final_result = (idx_ff == res_ff.count - 3'd1);

   // a read request needs the oldest cooked byte, an erase needs the last raw byte
   assign rd_addr = (req_kind_type'(req_tuser) == REQ_READ) ? start_ptr_ff
                  : ((raw_ptr_ff == '0) ? LAST_PTR : raw_ptr_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (wr_en && state_ff == ST_DECIDE) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   ttyld_step #(
      .BUF_DEPTH(BUF_DEPTH),
      .PTR_W(PTR_W)
   ) u_step (
      .req_type        (req_type_ff),
      .in_byte         (in_byte_ff),
      .cfg             (cfg_ff),
      .rd_data         (rd_data_ff),
      .start_ptr       (start_ptr_ff),
      .cooked_ptr      (cooked_ptr_ff),
      .raw_ptr         (raw_ptr_ff),
      .start_ptr_next  (start_ptr_in),
      .cooked_ptr_next (cooked_ptr_in),
      .raw_ptr_next    (raw_ptr_in),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .res             (res_in)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire && final_result) begin
               state_in = req_fire ? ST_DECIDE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
         end
         ST_DECIDE: begin
            req_tready = 1'b0;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready && final_result;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rsp_tdata = {4'b0000, res_ff.readable, res_ff.drop, res_ff.sig,
                       res_ff.bytes[idx_ff]};
   assign rsp_tuser = res_ff.kind;
   assign rsp_tlast = final_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_ptr_ff  <= '0;
         cooked_ptr_ff <= '0;
         raw_ptr_ff    <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DECIDE) begin
            start_ptr_ff  <= start_ptr_in;
            cooked_ptr_ff <= cooked_ptr_in;
            raw_ptr_ff    <= raw_ptr_in;
            idx_ff        <= '0;
         end else if (rsp_fire) begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff <= req_kind_type'(req_tuser);
         in_byte_ff  <= req_tdata;
      end
      if (state_ff == ST_DECIDE) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_flags    <= LOCAL_FLAGS_RESET;
         cfg_ff.newline_expand <= NEWLINE_EXPAND_RESET;
         cfg_ff.eof_char       <= EOF_CHAR_RESET;
         cfg_ff.intr_char      <= INTR_CHAR_RESET;
         cfg_ff.susp_char      <= SUSP_CHAR_RESET;
         cfg_ff.quit_char      <= QUIT_CHAR_RESET;
         cfg_ff.tty_attached   <= TTY_ATTACHED_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOCAL_FLAGS:    cfg_ff.local_flags    <= csr_wdata[5:0];
            CSR_NEWLINE_EXPAND: cfg_ff.newline_expand <= csr_wdata[0];
            CSR_EOF_CHAR:       cfg_ff.eof_char       <= csr_wdata;
            CSR_INTR_CHAR:      cfg_ff.intr_char      <= csr_wdata;
            CSR_SUSP_CHAR:      cfg_ff.susp_char      <= csr_wdata;
            CSR_QUIT_CHAR:      cfg_ff.quit_char      <= csr_wdata;
            CSR_TTY_ATTACHED:   cfg_ff.tty_attached   <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (res_ff.count != 3'd0 && res_ff.count <= 3'd6))
      else $error("result count out of range");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff < res_ff.count)
      else $error("result index past count");

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_DECIDE)
      else $error("accepted request did not enter decide");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      start_ptr_ff <= LAST_PTR && cooked_ptr_ff <= LAST_PTR && raw_ptr_ff <= LAST_PTR)
      else $error("pointer beyond buffer depth");

endmodule

`default_nettype wire
